// ===== hw/rtl/spd_pkg.sv =====
`default_nettype none
package spd_pkg;

  localparam int SPD_BYTE_W = 8;
  localparam int SPD_MAX_PATTERN = 8;
  localparam int SPD_PAT_W = 64;
  localparam int SPD_LEN_W = 4;
  localparam int SPD_IDX_W = 2;

  localparam logic [SPD_IDX_W-1:0] SPD_REG_PATTERN = 2'd0;
  localparam logic [SPD_IDX_W-1:0] SPD_REG_LENGTH  = 2'd1;

  typedef struct packed {
    logic [SPD_BYTE_W-1:0] kept_byte;
    logic                  kept_valid;
    logic                  stream_last;
  } spd_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spd_cell.sv =====
`default_nettype none
module spd_cell (
  input  wire                           clk,
  input  wire                           wr,
  input  wire                           shift,
  input  wire [spd_pkg::SPD_BYTE_W-1:0] text_byte,
  input  wire [spd_pkg::SPD_BYTE_W-1:0] nb_byte,
  input  wire [spd_pkg::SPD_BYTE_W-1:0] pat_byte,
  output logic [spd_pkg::SPD_BYTE_W-1:0] win_byte,
  output logic                          eq
);
  import spd_pkg::*;

  logic [SPD_BYTE_W-1:0] held;

  assign win_byte = wr ? text_byte : held;
  assign eq       = (win_byte == pat_byte);

  always_ff @(posedge clk) begin
    held <= shift ? nb_byte : win_byte;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_out_fifo.sv =====
`default_nettype none
module spd_out_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire spd_pkg::spd_result_t din,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_ready,
  output spd_pkg::spd_result_t dout
);
  import spd_pkg::*;

  spd_result_t e0;
  spd_result_t e1;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign dout      = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        e0 <= din;
      end else begin
        e0 <= e1;
        if (push) begin
          e1 <= din;
        end
      end
    end else if (push) begin
      if (count == 2'd0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stream_pattern_deleter_unit.sv =====
`default_nettype none
// Output: a surviving byte is registered in the output queue and leaves from its head.
// Throughput: one byte per cycle when the output queue has room; an end-of-text byte with
// bytes left in the window starts a flush from the cell row before new input is taken.
// The output queue holds two results, so input continues while a result waits.
// Reset: synchronous, active high; empties the window, pattern 0, length 1.
module stream_pattern_deleter_unit #(
  parameter int MAX_PATTERN = spd_pkg::SPD_MAX_PATTERN
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [spd_pkg::SPD_IDX_W-1:0]   cfg_index,
  input  wire [spd_pkg::SPD_PAT_W-1:0]   cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [spd_pkg::SPD_BYTE_W-1:0]  text_byte,
  input  wire                            text_end,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [spd_pkg::SPD_BYTE_W-1:0] kept_byte,
  output logic                           kept_valid,
  output logic                           stream_last
);
  import spd_pkg::*;

  localparam logic [SPD_LEN_W-1:0] MaxLen = SPD_LEN_W'(MAX_PATTERN);

  logic [SPD_PAT_W-1:0]  pattern;
  logic [SPD_LEN_W-1:0]  len;
  logic [SPD_LEN_W-1:0]  fill;
  logic [SPD_LEN_W-1:0]  fill_next;
  logic                  draining;
  logic                  draining_next;
  logic [SPD_LEN_W-1:0]  len_wr;

  logic [SPD_BYTE_W-1:0] win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic                  accept;
  logic                  full_win;
  logic                  match;
  logic                  emit;
  logic                  shift;
  logic                  drain_pop;
  logic [SPD_LEN_W-1:0]  nf;
  logic                  fifo_full;
  logic                  push;
  spd_result_t           push_data;
  spd_result_t           head;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !draining && !fifo_full;
  assign full_win  = ((fill + SPD_LEN_W'(1)) == len);
  assign emit      = accept && full_win && !match;
  assign drain_pop = draining && !fifo_full;
  assign shift     = emit || drain_pop;
  assign nf        = full_win ? (match ? '0 : len - SPD_LEN_W'(1)) : fill + SPD_LEN_W'(1);

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (SPD_LEN_W'(k) < len && !eq[k]) begin
        match = 1'b0;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      logic [SPD_BYTE_W-1:0] nb;
      if (g == MAX_PATTERN - 1) begin : g_tail
        assign nb = text_byte;
      end else begin : g_mid
        assign nb = win[g+1];
      end
      spd_cell u_cell (
        .clk      (clk),
        .wr       (accept && fill == SPD_LEN_W'(g)),
        .shift    (shift),
        .text_byte(text_byte),
        .nb_byte  (nb),
        .pat_byte (pattern[SPD_BYTE_W*g +: SPD_BYTE_W]),
        .win_byte (win[g]),
        .eq       (eq[g])
      );
    end
  endgenerate

  always_comb begin
    push          = 1'b0;
    push_data     = '{kept_byte: win[0], kept_valid: 1'b1, stream_last: 1'b0};
    fill_next     = fill;
    draining_next = draining;
    if (accept) begin
      fill_next = nf;
      if (text_end) begin
        draining_next = (nf != '0);
        if (emit) begin
          push                  = 1'b1;
          push_data.stream_last = (nf == '0);
        end else if (nf == '0) begin
          push      = 1'b1;
          push_data = '{kept_byte: '0, kept_valid: 1'b0, stream_last: 1'b1};
        end
      end else begin
        push = emit;
      end
    end else if (drain_pop) begin
      push                  = 1'b1;
      push_data.stream_last = (fill == SPD_LEN_W'(1));
      fill_next             = fill - SPD_LEN_W'(1);
      draining_next         = (fill != SPD_LEN_W'(1));
    end
  end

  always_comb begin
    len_wr = cfg_data[SPD_LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = SPD_LEN_W'(1);
    end else if (len_wr > MaxLen) begin
      len_wr = MaxLen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern  <= '0;
      len      <= SPD_LEN_W'(1);
      fill     <= '0;
      draining <= 1'b0;
    end else begin
      fill     <= fill_next;
      draining <= draining_next;
      if (cfg_we) begin
        case (cfg_index)
          SPD_REG_PATTERN: pattern <= cfg_data;
          SPD_REG_LENGTH: begin
            len  <= len_wr;
            fill <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  spd_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (push_data),
    .full     (fifo_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (head)
  );

  assign kept_byte   = head.kept_byte;
  assign kept_valid  = head.kept_valid;
  assign stream_last = head.stream_last;

endmodule
`default_nettype wire

// ===== sim/spd_deletion_checker.sv =====
module spd_deletion_checker #(
  parameter int MAX_PATTERN = spd_pkg::SPD_MAX_PATTERN
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [spd_pkg::SPD_IDX_W-1:0]   cfg_index,
  input  wire [spd_pkg::SPD_PAT_W-1:0]   cfg_data,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire [spd_pkg::SPD_BYTE_W-1:0]  text_byte,
  input  wire                            text_end,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire [spd_pkg::SPD_BYTE_W-1:0]  kept_byte,
  input  wire                            kept_valid,
  input  wire                            stream_last,
  output int                             failures,
  output int                             pending,
  output int                             checked_results,
  output int                             removed_patterns
);
  import spd_pkg::*;

  int fail_count = 0;
  int pending_count = 0;
  int checked_count = 0;
  int removed_count = 0;

  logic [SPD_PAT_W-1:0]  pattern_reg = '0;
  logic [SPD_LEN_W-1:0]  length_reg = 4'd1;
  logic [SPD_BYTE_W-1:0] window [8];
  int unsigned           window_fill = 0;
  spd_result_t           survivors_q [$];

  assign failures = fail_count;
  assign pending = pending_count;
  assign checked_results = checked_count;
  assign removed_patterns = removed_count;

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  task automatic predict_survivors(input logic [SPD_BYTE_W-1:0] b, input logic last);
    int unsigned len;
    int n;
    bit hit;
    spd_result_t r;
    len = (length_reg == 0) ? 1 : ((length_reg > MAX_PATTERN) ? MAX_PATTERN : length_reg);
    n = 0;
    if (window_fill >= len) window_fill = len - 1;
    window[window_fill] = b;
    window_fill++;
    if (window_fill == len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (window[k] != pattern_reg[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        window_fill = 0;
        removed_count++;
      end else begin
        r.kept_byte = window[0];
        r.kept_valid = 1'b1;
        r.stream_last = 1'b0;
        survivors_q.push_back(r);
        n++;
        for (int k = 0; k < 7; k++) window[k] = window[k + 1];
        window_fill--;
      end
    end
    if (last) begin
      for (int k = 0; k < window_fill; k++) begin
        r.kept_byte = window[k];
        r.kept_valid = 1'b1;
        r.stream_last = 1'b0;
        survivors_q.push_back(r);
        n++;
      end
      window_fill = 0;
      if (n == 0) begin
        r.kept_byte = '0;
        r.kept_valid = 1'b0;
      end else begin
        r = survivors_q.pop_back();
      end
      r.stream_last = 1'b1;
      survivors_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    spd_result_t want;
    if (rst) begin
      pattern_reg = '0;
      length_reg = 4'd1;
      window_fill = 0;
      survivors_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (survivors_q.size() == 0) begin
          $error("result with nothing expected: kept_byte 0x%0h kept_valid %0b stream_last %0b",
                 kept_byte, kept_valid, stream_last);
          fail_count++;
        end else begin
          want = survivors_q.pop_front();
          compare_field("kept_byte", want.kept_byte, kept_byte);
          compare_field("kept_valid", 8'(want.kept_valid), 8'(kept_valid));
          compare_field("stream_last", 8'(want.stream_last), 8'(stream_last));
          checked_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          SPD_REG_PATTERN: pattern_reg = cfg_data;
          SPD_REG_LENGTH: begin
            length_reg = cfg_data[SPD_LEN_W-1:0];
            window_fill = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_survivors(text_byte, text_end);
    end
    pending_count = survivors_q.size();
  end

endmodule

// ===== sim/tb_stream_pattern_deleter_unit.sv =====
module tb_stream_pattern_deleter_unit;
  import spd_pkg::*;

  localparam logic [SPD_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [SPD_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [SPD_IDX_W-1:0]  cfg_index = '0;
  logic [SPD_PAT_W-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SPD_BYTE_W-1:0] text_byte = '0;
  logic                  text_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SPD_BYTE_W-1:0] kept_byte;
  logic                  kept_valid;
  logic                  stream_last;

  int failures, pending, checked_results, removed_patterns;
  int send_gap_pct = 17;
  int recv_gap_pct = 48;
  int cycles = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int settings_used = 0;

  logic [SPD_PAT_W-1:0]  pattern = '0;
  int unsigned           pat_len = 1;
  logic [SPD_BYTE_W-1:0] alphabet [2];

  stream_pattern_deleter_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte), .text_end(text_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_byte(kept_byte), .kept_valid(kept_valid), .stream_last(stream_last)
  );

  spd_deletion_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte), .text_end(text_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept_byte(kept_byte), .kept_valid(kept_valid), .stream_last(stream_last),
    .failures(failures), .pending(pending),
    .checked_results(checked_results), .removed_patterns(removed_patterns)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stream_pattern_deleter_unit verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_gap_pct);
  end

  task automatic send_text_byte(input logic [SPD_BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      text_byte <= SPD_BYTE_W'($urandom_range(255));
      text_end <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    text_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [SPD_IDX_W-1:0] idx, input logic [SPD_PAT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == SPD_REG_LENGTH) settings_used++;
  endtask

  task automatic send_random_text();
    int unsigned target, r, cut;
    logic [SPD_BYTE_W-1:0] chunk [$];
    target = $urandom_range(24, 1);
    while (chunk.size() < target) begin
      r = $urandom_range(9);
      if (r < 4) cut = pat_len;
      else if (r < 6) cut = $urandom_range(pat_len, 1);
      else cut = 0;
      if (cut > 0) begin
        for (int k = 0; k < cut; k++) chunk.push_back(pattern[8*k +: 8]);
      end else if (r < 8) begin
        chunk.push_back(alphabet[$urandom_range(1)]);
      end else begin
        chunk.push_back(SPD_BYTE_W'($urandom_range(255)));
      end
    end
    foreach (chunk[i]) send_text_byte(chunk[i], i == chunk.size() - 1);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int start;
    logic [SPD_LEN_W-1:0] raw_len;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      drain();
      alphabet[0] = SPD_BYTE_W'($urandom_range(255));
      alphabet[1] = SPD_BYTE_W'($urandom_range(255));
      case ($urandom_range(5))
        0: raw_len = 4'd1;
        1: raw_len = 4'd8;
        2: raw_len = SPD_LEN_W'($urandom_range(15, 9));
        3: raw_len = 4'd0;
        default: raw_len = SPD_LEN_W'($urandom_range(7, 2));
      endcase
      for (int k = 0; k < 8; k++) begin
        pattern[8*k +: 8] = ($urandom_range(3) == 0) ? SPD_BYTE_W'($urandom_range(255))
                                                      : alphabet[$urandom_range(1)];
      end
      if ($urandom_range(9) == 0) pattern = '1;
      else if ($urandom_range(9) == 0) pattern = '0;
      pat_len = (raw_len == 0) ? 1 : ((raw_len > 8) ? 8 : raw_len);
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
      end
      write_reg(SPD_REG_PATTERN, pattern);
      write_reg(SPD_REG_LENGTH, {{(SPD_PAT_W-SPD_LEN_W){1'b0}}, raw_len});
      repeat ($urandom_range(5, 2)) send_random_text();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pattern is a single zero byte
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'hFF, 1'b1);

    drain();
    write_reg(SPD_REG_PATTERN, 64'h0000_0000_0041_FF00);
    write_reg(SPD_REG_LENGTH, 64'd3);
    send_text_byte(8'h00, 1'b0); send_text_byte(8'hFF, 1'b0); send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h00, 1'b0); send_text_byte(8'hFF, 1'b0); send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0); send_text_byte(8'h41, 1'b0); send_text_byte(8'hFF, 1'b1);
    send_text_byte(8'h00, 1'b0); send_text_byte(8'hFF, 1'b0); send_text_byte(8'h41, 1'b1);
    send_text_byte(8'h00, 1'b0); send_text_byte(8'hFF, 1'b1);

    // length rewrite drops a partly filled window
    send_text_byte(8'h41, 1'b0);
    drain();
    write_reg(SPD_REG_LENGTH, 64'd0);
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'h41, 1'b1);

    // pattern rewrite keeps the window
    drain();
    write_reg(SPD_REG_LENGTH, 64'd15);
    write_reg(SPD_REG_PATTERN, 64'h0);
    repeat (3) send_text_byte(8'hFF, 1'b0);
    drain();
    write_reg(REG_SPARE_LO, 64'h0);
    write_reg(REG_SPARE_HI, '1);
    write_reg(SPD_REG_PATTERN, '1);
    repeat (4) send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'hFF, 1'b1);

    run_phase(17, 48);
    run_phase(48, 17);
    run_phase(0, 0);
    drain();

    $display("Ran %0d text bytes in %0d texts across %0d length settings and three idle mixes;",
             bytes_sent, texts_sent, settings_used);
    $display("checked %0d results, saw %0d pattern deletions, %0d mismatches.",
             checked_results, removed_patterns, failures);
    if (failures == 0) begin
      $display("stream_pattern_deleter_unit verification clean");
    end else begin
      $display("stream_pattern_deleter_unit verification failed");
    end
    $finish;
  end

endmodule
